### sv/tscs_pkg.sv
// ----------------------------------------------------------------------------
// Task core status package
// Shared widths, codes, per-core row layout and controller/datapath links.
// ----------------------------------------------------------------------------
package tscs_pkg;

    localparam int unsigned TSCS_CORES        = 64;
    localparam int unsigned TSCS_FUNC_ENTRIES = 1024;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned CORE_W   = 6;
    localparam int unsigned TASK_W   = 31;
    localparam int unsigned FID_W    = 10;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned ENT_W    = 40;
    localparam int unsigned LAT_W    = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

    // status kinds
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIN  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_LAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LAT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTICE_LAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_DUR    = 3'd4;

    localparam logic [TIME_W-1:0] SEED_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam int unsigned DRAW_SHIFT = 20;

    typedef struct packed {
        logic              active_valid;
        logic [TASK_W-1:0] active_task;
        logic [TIME_W-1:0] active_ack_time;
        logic [TIME_W-1:0] active_finish_time;
        logic              pushed_valid;
        logic [TASK_W-1:0] pushed_task;
        logic [TIME_W-1:0] pushed_duration;
        logic [KIND_W-1:0] shown_kind;
        logic [TASK_W-1:0] shown_task;
        logic [TIME_W-1:0] core_rng;
    } t_row;

    typedef struct packed {
        logic [ENT_W-1:0] mean;
        logic [ENT_W-1:0] sigma;
    } t_frow;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DL, S_RNG, S_MLO, S_MHI, S_DEV,
        S_DUR, S_ACK, S_FIN, S_NOW, S_ADV, S_WB, S_LOAD
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic fetch;
        logic dl;
        logic rng;
        logic mlo;
        logic mhi;
        logic dev;
        logic dur;
        logic ack;
        logic fin;
        logic now;
        logic adv;
        logic wb;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic            clr_done;
        logic [OP_W-1:0] op;
        logic            core_ok;
        logic            sigma_nz;
        logic            rng_last;
        logic            adv_done;
        logic            res_full;
    } t_sts;

endpackage

### sv/tscs_ifs.sv
// ----------------------------------------------------------------------------
// Task core status channels
// Valid/ready request and status channels.
// ----------------------------------------------------------------------------
interface tscs_in_if;
    logic                              valid;
    logic                              ready;
    logic [tscs_pkg::OP_W-1:0]         operation;
    logic [tscs_pkg::CORE_W-1:0]       core;
    logic [tscs_pkg::TASK_W-1:0]       task_req;
    logic [tscs_pkg::FID_W-1:0]        function_id;
    logic [tscs_pkg::TIME_W-1:0]       current_time;
    logic [tscs_pkg::ENT_W-1:0]        entry_mean;
    logic [tscs_pkg::ENT_W-1:0]        entry_sigma;

    modport source (output valid, operation, core, task_req, function_id,
                    current_time, entry_mean, entry_sigma, input ready);
    modport sink   (input valid, operation, core, task_req, function_id,
                    current_time, entry_mean, entry_sigma, output ready);
endinterface

interface tscs_out_if;
    logic                        valid;
    logic                        ready;
    logic [tscs_pkg::KIND_W-1:0] status_kind;
    logic [tscs_pkg::TASK_W-1:0] status_task;

    modport source (output valid, status_kind, status_task, input ready);
    modport sink   (input valid, status_kind, status_task, output ready);
endinterface

### sv/tscs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tscs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/tscs_ctrl.sv
// ----------------------------------------------------------------------------
// Task core status controller
// Sequences table clear, fetch, duration draw, advance, write-back and table load.
// ----------------------------------------------------------------------------
module tscs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tscs_pkg::t_sts  i_sts,
    output tscs_pkg::t_cmd  o_cmd
);
    tscs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tscs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tscs_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) n_state = tscs_pkg::S_IDLE;
            end
            tscs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = tscs_pkg::S_FETCH;
                end
            end
            tscs_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                unique case (i_sts.op)
                    tscs_pkg::OP_PUSH:
                        n_state = i_sts.core_ok ? tscs_pkg::S_DL : tscs_pkg::S_IDLE;
                    tscs_pkg::OP_READ: n_state = tscs_pkg::S_NOW;
                    tscs_pkg::OP_LOAD: n_state = tscs_pkg::S_LOAD;
                    default:           n_state = tscs_pkg::S_IDLE;
                endcase
            end
            tscs_pkg::S_DL: begin
                o_cmd.dl = 1'b1;
                n_state  = i_sts.sigma_nz ? tscs_pkg::S_RNG : tscs_pkg::S_ACK;
            end
            tscs_pkg::S_RNG: begin
                o_cmd.rng = 1'b1;
                if (i_sts.rng_last) n_state = tscs_pkg::S_MLO;
            end
            tscs_pkg::S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state   = tscs_pkg::S_MHI;
            end
            tscs_pkg::S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state   = tscs_pkg::S_DEV;
            end
            tscs_pkg::S_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = tscs_pkg::S_DUR;
            end
            tscs_pkg::S_DUR: begin
                o_cmd.dur = 1'b1;
                n_state   = tscs_pkg::S_ACK;
            end
            tscs_pkg::S_ACK: begin
                o_cmd.ack = 1'b1;
                n_state   = tscs_pkg::S_FIN;
            end
            tscs_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = tscs_pkg::S_WB;
            end
            tscs_pkg::S_NOW: begin
                o_cmd.now = 1'b1;
                n_state   = tscs_pkg::S_ADV;
            end
            tscs_pkg::S_ADV: begin
                o_cmd.adv = 1'b1;
                if (i_sts.adv_done) n_state = tscs_pkg::S_WB;
            end
            tscs_pkg::S_WB: begin
                // a read waits here until the result register frees up
                if (!(i_sts.op == tscs_pkg::OP_READ && i_sts.res_full)) begin
                    o_cmd.wb = 1'b1;
                    n_state  = tscs_pkg::S_IDLE;
                end
            end
            tscs_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = tscs_pkg::S_IDLE;
            end
            default: n_state = tscs_pkg::S_IDLE;
        endcase
    end
endmodule

### sv/tscs_dp.sv
// ----------------------------------------------------------------------------
// Task core status datapath
// Per-core row memory, function table, duration draw and advance logic.
// ----------------------------------------------------------------------------
module tscs_dp #(
    parameter int unsigned CORES        = tscs_pkg::TSCS_CORES,
    parameter int unsigned FUNC_ENTRIES = tscs_pkg::TSCS_FUNC_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tscs_pkg::t_cmd                  i_cmd,
    output tscs_pkg::t_sts                  o_sts,
    input  logic [tscs_pkg::OP_W-1:0]       i_operation,
    input  logic [tscs_pkg::CORE_W-1:0]     i_core,
    input  logic [tscs_pkg::TASK_W-1:0]     i_task_req,
    input  logic [tscs_pkg::FID_W-1:0]      i_function_id,
    input  logic [tscs_pkg::TIME_W-1:0]     i_current_time,
    input  logic [tscs_pkg::ENT_W-1:0]      i_entry_mean,
    input  logic [tscs_pkg::ENT_W-1:0]      i_entry_sigma,
    input  logic                            i_cfg_we,
    input  logic [tscs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tscs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [tscs_pkg::KIND_W-1:0]     o_status_kind,
    output logic [tscs_pkg::TASK_W-1:0]     o_status_task
);
    localparam int unsigned CW = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int unsigned FW = (FUNC_ENTRIES > 1) ? $clog2(FUNC_ENTRIES) : 1;
    localparam int unsigned RW = $bits(tscs_pkg::t_row);
    localparam int unsigned FRW = $bits(tscs_pkg::t_frow);
    localparam int unsigned TW = tscs_pkg::TIME_W;
    localparam int unsigned EW = tscs_pkg::ENT_W;
    localparam int unsigned HW = EW / 2;          // sigma half width
    localparam int unsigned MW = 22;              // |sum| <= 3*2^20
    localparam int unsigned PW = HW + MW;
    localparam int unsigned SW = 23;              // signed draw sum

    // config
    logic [tscs_pkg::LAT_W-1:0] r_push_lat, r_read_lat, r_ack_lat, r_notice_lat;
    logic [EW-1:0]              r_def_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_lat   <= '0;
            r_read_lat   <= '0;
            r_ack_lat    <= '0;
            r_notice_lat <= '0;
            r_def_dur    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tscs_pkg::CFG_PUSH_LAT:   r_push_lat   <= i_cfg_wdata[tscs_pkg::LAT_W-1:0];
                tscs_pkg::CFG_READ_LAT:   r_read_lat   <= i_cfg_wdata[tscs_pkg::LAT_W-1:0];
                tscs_pkg::CFG_ACK_LAT:    r_ack_lat    <= i_cfg_wdata[tscs_pkg::LAT_W-1:0];
                tscs_pkg::CFG_NOTICE_LAT: r_notice_lat <= i_cfg_wdata[tscs_pkg::LAT_W-1:0];
                tscs_pkg::CFG_DEF_DUR:    r_def_dur    <= i_cfg_wdata[EW-1:0];
                default: ;
            endcase
        end
    end

    // latched request
    logic [tscs_pkg::OP_W-1:0]   r_op;
    logic [tscs_pkg::CORE_W-1:0] r_core;
    logic [tscs_pkg::TASK_W-1:0] r_task;
    logic [tscs_pkg::FID_W-1:0]  r_fid;
    logic [TW-1:0]               r_cur;
    logic [EW-1:0]               r_emean, r_esig;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_operation;
            r_core  <= i_core;
            r_task  <= i_task_req;
            r_fid   <= i_function_id;
            r_cur   <= i_current_time;
            r_emean <= i_entry_mean;
            r_esig  <= i_entry_sigma;
        end
    end

    logic [10:0] in_core_ext, core_ext;
    logic [12:0] in_fid_ext, fid_ext;
    logic [CW-1:0] in_cidx, cidx;
    logic [FW-1:0] in_fidx, fidx;
    logic core_ok, fid_ok;

    assign in_core_ext = {5'b0, i_core};
    assign core_ext    = {5'b0, r_core};
    assign in_fid_ext  = {3'b0, i_function_id};
    assign fid_ext     = {3'b0, r_fid};
    assign in_cidx     = in_core_ext[CW-1:0];
    assign cidx        = core_ext[CW-1:0];
    assign in_fidx     = in_fid_ext[FW-1:0];
    assign fidx        = fid_ext[FW-1:0];
    assign core_ok     = core_ext < 11'(CORES);
    assign fid_ok      = fid_ext < 13'(FUNC_ENTRIES);

    // per-core row valid bits: a row never written reads as its reset value
    logic [CORES-1:0] r_row_vld;
    logic             r_vld_q;

    // clearing pass over the function table
    logic [FW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // memories
    tscs_pkg::t_row  row_rdata, row_wdata;
    tscs_pkg::t_frow frow_rdata, frow_wdata;
    logic            func_we;
    logic [FW-1:0]   func_waddr;
    logic            row_we;

    tscs_ram #(.WIDTH(RW), .DEPTH(CORES)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (cidx),
        .i_wdata (row_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (in_cidx),
        .o_rdata (row_rdata)
    );

    tscs_ram #(.WIDTH(FRW), .DEPTH(FUNC_ENTRIES)) u_func_ram (
        .i_clk   (i_clk),
        .i_we    (func_we),
        .i_waddr (func_waddr),
        .i_wdata (frow_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (in_fidx),
        .o_rdata (frow_rdata)
    );

    assign func_we    = i_cmd.clear || (i_cmd.load && fid_ok);
    assign func_waddr = i_cmd.clear ? r_clr : fidx;
    assign frow_wdata = i_cmd.clear ? '0 : {r_emean, r_esig};

    // working registers
    tscs_pkg::t_row  r_row, n_row, row_reset, row_adv;
    logic [EW-1:0]   r_mean, r_sig;
    logic [TW-1:0]   r_a, r_ack, r_fin, r_dur;
    logic [SW-1:0]   r_sum;
    logic [1:0]      r_rcnt;
    logic            r_neg;
    logic [MW-1:0]   r_mag;
    logic [PW-1:0]   r_plo, r_phi;
    logic [PW-1:0]   r_dev;
    logic            promote;

    always_comb begin
        row_reset          = '0;
        row_reset.core_rng = (tscs_pkg::SEED_MUL * {53'b0, core_ext} +
                              tscs_pkg::SEED_MUL) | 64'd1;
    end

    // xorshift step
    logic [TW-1:0] x0, x1, x2;
    logic [SW-1:0] draw;
    always_comb begin
        x0   = r_row.core_rng ^ (r_row.core_rng << 13);
        x1   = x0 ^ (x0 >> 7);
        x2   = x1 ^ (x1 << 17);
        // low 21 bits minus 2^20 is the top bit flipped, read as signed
        draw = {{2{~x2[20]}}, ~x2[20], x2[19:0]};
    end

    // one advance pass
    logic [TW-1:0] now_fin_notice;
    always_comb begin
        row_adv        = r_row;
        promote        = 1'b0;
        now_fin_notice = r_row.active_finish_time + {32'b0, r_notice_lat};
        if (r_row.active_valid) begin
            if (r_a >= r_row.active_finish_time) begin
                if (r_row.pushed_valid) begin
                    promote                    = 1'b1;
                    row_adv.active_task        = r_row.pushed_task;
                    row_adv.active_ack_time    = r_row.active_finish_time;
                    row_adv.active_finish_time = r_row.active_finish_time +
                                                 r_row.pushed_duration;
                    row_adv.pushed_valid       = 1'b0;
                    row_adv.pushed_task        = '0;
                    row_adv.pushed_duration    = '0;
                end else if (r_a >= now_fin_notice) begin
                    row_adv.shown_kind   = tscs_pkg::KIND_FIN;
                    row_adv.shown_task   = r_row.active_task;
                    row_adv.active_valid = 1'b0;
                end
            end else if (r_a >= r_row.active_ack_time) begin
                row_adv.shown_kind = tscs_pkg::KIND_ACK;
                row_adv.shown_task = r_row.active_task;
            end
        end
    end

    // duration arithmetic
    logic [SW-1:0]   abs_sum;
    logic [PW+HW:0]  prod;
    logic [PW+HW:0]  prod_rnd;
    logic signed [EW+3:0] dur_s;
    always_comb begin
        abs_sum  = r_sum[SW-1] ? (~r_sum + 1'b1) : r_sum;
        prod     = {{(HW+1){1'b0}}, r_plo} + {1'b0, r_phi, {HW{1'b0}}};
        prod_rnd = prod + {{(PW+1){1'b0}}, {tscs_pkg::DRAW_SHIFT{1'b1}}};
        dur_s    = r_neg ? ($signed({4'b0, r_mean}) - $signed({2'b0, r_dev}))
                         : ($signed({4'b0, r_mean}) + $signed({2'b0, r_dev}));
    end

    logic sel_tab;
    assign sel_tab = fid_ok && (frow_rdata.mean != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_vld_q <= r_row_vld[in_cidx];
        end
        if (i_cmd.fetch) begin
            r_row  <= r_vld_q ? row_rdata : row_reset;
            r_mean <= sel_tab ? frow_rdata.mean : r_def_dur;
            r_sig  <= sel_tab ? frow_rdata.sigma : '0;
            r_dur  <= TW'(sel_tab ? frow_rdata.mean : r_def_dur);
            r_sum  <= '0;
            r_rcnt <= '0;
        end
        if (i_cmd.dl) begin
            r_a <= r_cur + {32'b0, r_push_lat};
        end
        if (i_cmd.now) begin
            r_a <= r_cur + {32'b0, r_read_lat};
        end
        if (i_cmd.rng) begin
            r_row.core_rng <= x2;
            r_sum          <= r_sum + draw;
            r_rcnt         <= r_rcnt + 1'b1;
        end
        if (i_cmd.mlo) begin
            r_neg <= r_sum[SW-1];
            r_mag <= abs_sum[MW-1:0];
            r_plo <= r_sig[HW-1:0] * abs_sum[MW-1:0];
        end
        if (i_cmd.mhi) begin
            r_phi <= r_sig[EW-1:HW] * r_mag;
        end
        if (i_cmd.dev) begin
            r_dev <= r_neg ? prod_rnd[PW+HW-1:tscs_pkg::DRAW_SHIFT]
                           : prod[PW+HW-1:tscs_pkg::DRAW_SHIFT];
        end
        if (i_cmd.dur) begin
            r_dur <= (dur_s < 1) ? TW'(1) : TW'(dur_s[EW+2:0]);
        end
        if (i_cmd.ack) begin
            r_ack <= r_a + {32'b0, r_ack_lat};
        end
        if (i_cmd.fin) begin
            r_fin <= r_ack + r_dur;
        end
        if (i_cmd.adv) begin
            r_row <= row_adv;
        end
    end

    // write-back row
    always_comb begin
        n_row = r_row;
        if (r_op == tscs_pkg::OP_PUSH) begin
            if (!r_row.active_valid) begin
                n_row.active_valid       = 1'b1;
                n_row.active_task        = r_task;
                n_row.active_ack_time    = r_ack;
                n_row.active_finish_time = r_fin;
            end else begin
                n_row.pushed_valid    = 1'b1;
                n_row.pushed_task     = r_task;
                n_row.pushed_duration = r_dur;
            end
        end
    end

    assign row_wdata = n_row;
    assign row_we    = i_cmd.wb && core_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (row_we) begin
            r_row_vld[cidx] <= 1'b1;
        end
    end

    // result register
    logic                         r_res_vld;
    logic [tscs_pkg::KIND_W-1:0]  r_res_kind;
    logic [tscs_pkg::TASK_W-1:0]  r_res_task;
    logic                         set_res;

    assign set_res = i_cmd.wb && (r_op == tscs_pkg::OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (set_res) begin
            r_res_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_res_vld <= 1'b0;
        end
        if (set_res) begin
            r_res_kind <= core_ok ? r_row.shown_kind : tscs_pkg::KIND_IDLE;
            r_res_task <= core_ok ? r_row.shown_task : '0;
        end
    end

    assign o_out_valid   = r_res_vld;
    assign o_status_kind = r_res_kind;
    assign o_status_task = r_res_task;

    always_comb begin
        o_sts          = '0;
        o_sts.clr_done = (32'(r_clr) == FUNC_ENTRIES - 1);
        o_sts.op       = r_op;
        o_sts.core_ok  = core_ok;
        o_sts.sigma_nz = (r_sig != '0);
        o_sts.rng_last = (r_rcnt == 2'd2);
        o_sts.adv_done = !promote;
        o_sts.res_full = r_res_vld && !i_out_ready;
    end
endmodule

### sv/two_slot_task_core_status.sv
// ----------------------------------------------------------------------------
// Two-slot task core status
// Per-core active/pushed task slots with drawn durations and status reads.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Payload
//  i_in      in   valid/ready      operation, core, task_req, function_id,
//                                  current_time, entry_mean, entry_sigma
//  o_out     out  valid/ready      status_kind, status_task (reads only)
//  i_cfg_*   in   write enable     register index, 40-bit write data
//
//  One request at a time; ready is high only while the sequencer is idle.
//  A load writes the function table entry; a read advances the row, with an
//  extra pass when a pushed task is promoted; a push with nonzero sigma adds
//  three xorshift steps, two half-width multiplies, rounding and clamp. The
//  per-core row memory read and write-back bound each push and read.
//  After reset the function table is cleared, one entry per cycle, through all
//  FUNC_ENTRIES entries; no request is taken meanwhile, config writes are.
//  A read result sits in an output register; a following read stalls at
//  write-back until the previous result transfer completes.
//
module two_slot_task_core_status #(
    parameter int unsigned CORES        = tscs_pkg::TSCS_CORES,
    parameter int unsigned FUNC_ENTRIES = tscs_pkg::TSCS_FUNC_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tscs_in_if.sink                         i_in,
    tscs_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tscs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tscs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    tscs_pkg::t_cmd cmd;
    tscs_pkg::t_sts sts;
    logic           in_ready;

    // sequencer
    tscs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // row memory, function table and arithmetic
    tscs_dp #(
        .CORES        (CORES),
        .FUNC_ENTRIES (FUNC_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_in.operation),
        .i_core         (i_in.core),
        .i_task_req     (i_in.task_req),
        .i_function_id  (i_in.function_id),
        .i_current_time (i_in.current_time),
        .i_entry_mean   (i_in.entry_mean),
        .i_entry_sigma  (i_in.entry_sigma),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status_kind  (o_out.status_kind),
        .o_status_task  (o_out.status_task)
    );
endmodule
